// ===== sv/swmr_pkg.sv =====
package swmr_pkg;

  // channel set and window shape
  localparam int GYROS  = 3;
  localparam int AXES   = 3;
  localparam int WINDOW = 200;
  localparam int WARMUP = 400;

  localparam int CH     = GYROS * AXES;
  localparam int CH_W   = (CH > 1) ? $clog2(CH) : 1;
  localparam int WIN_CW = $clog2(WINDOW);
  localparam int POS_W  = WIN_CW;
  localparam int DEPTH  = CH * WINDOW;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int WU_W   = $clog2(WARMUP + 1);

  // field widths
  localparam int IDX_W  = 2;
  localparam int X_W    = 24;
  localparam int RMS_W  = X_W - 1;
  localparam int MQ_W   = X_W - 1;

  // running sums: window of full-scale samples and of full-scale squares
  localparam int SUM_W  = X_W + WIN_CW;
  localparam int MAG_W  = SUM_W - 1;
  localparam int SQ_W   = 2 * X_W - 1 + WIN_CW;

  // serial divider by the window length
  localparam int DV_W   = SQ_W;
  localparam int DL_W   = $clog2(DV_W + 1);

  // serial multiplier for new^2 - old^2 = (new - old) * (new + old)
  localparam int MA_W   = X_W + 1;
  localparam int MB_W   = X_W;
  localparam int PR_W   = 2 * X_W;
  localparam int MC_W   = $clog2(MB_W + 1);

  // serial square root, two radicand bits per step
  localparam int RAD_W  = 2 * X_W;
  localparam int ROOT_W = X_W;
  localparam int REM_W  = ROOT_W + 2;
  localparam int SC_W   = $clog2(ROOT_W + 1);

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// ===== sv/sliding_window_mean_rms.sv =====
// channel  dir  beat fields (lowest bit first)
// -------  ---  ------------------------------------------------------------
// in_      in   tdata: rate_sample[23:0]; tuser: gyro_index[1:0], axis_index[3:2]
// out_     out  tdata: window_mean[23:0], innovation_rms[46:24], zero pad[47];
//               tuser: out_gyro[1:0], out_axis[3:2], ready_res[4]
//
// one sample at a time; a result is loaded once the serial divider, multiplier
// and square root are through (the second divide and the root only once the
// channel is ready), and the next sample is taken when the sequencer is back
// in idle; a held result stalls the sequencer in its last state
// an out-of-range channel skips the units and finishes with zero mean, rms and ready
// rst_n is synchronous; no clearing pass: per-channel wrap bits mask old slots

module sliding_window_mean_rms (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // rate_sample
  input  logic [3:0]  in_tuser,   // gyro_index, axis_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // window_mean, innovation_rms, pad
  output logic [4:0]  out_tuser   // out_gyro, out_axis, ready_res
);
  import swmr_pkg::*;

  // sequencer states
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_ADDR  = 4'd1;
  localparam logic [3:0] ST_READ  = 4'd2;
  localparam logic [3:0] ST_SUM   = 4'd3;
  localparam logic [3:0] ST_MDIV0 = 4'd4;
  localparam logic [3:0] ST_MDIV  = 4'd5;
  localparam logic [3:0] ST_INNOV = 4'd6;
  localparam logic [3:0] ST_MUL0  = 4'd7;
  localparam logic [3:0] ST_MUL   = 4'd8;
  localparam logic [3:0] ST_SDIV0 = 4'd9;
  localparam logic [3:0] ST_SDIV  = 4'd10;
  localparam logic [3:0] ST_SQRT  = 4'd11;
  localparam logic [3:0] ST_FIN   = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // per-channel state, cleared by reset
  logic [SUM_W-1:0] sum_arr_r  [CH];
  logic [SQ_W-1:0]  sq_arr_r   [CH];
  logic [POS_W-1:0] pos_arr_r  [CH];
  logic             wrap_arr_r [CH];
  logic [WU_W-1:0]  warm_arr_r [CH];

  // current item
  logic [IDX_W-1:0]  g_r;
  logic [IDX_W-1:0]  a_r;
  logic [X_W-1:0]    x_r;
  logic [CH_W-1:0]   c_r;
  logic              range_ok_r;
  logic [ADDR_W-1:0] addr_r;
  logic [X_W-1:0]    old_i_r;
  logic [X_W-1:0]    mean_r;
  logic [X_W-1:0]    innov_r;
  logic [RMS_W-1:0]  rms_r;
  logic              rdy_r;

  // output register
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic [4:0]  out_user_r;

  logic              in_acc;
  logic              out_load;
  logic              in_range;
  logic [CH_W-1:0]   c_in;

  // window slot and sums
  logic [2*X_W-1:0]  ram_rdata;
  logic              old_ok;
  logic [X_W-1:0]    old_x;
  logic [X_W-1:0]    old_i;
  logic [SUM_W-1:0]  sum_cur;
  logic [SUM_W-1:0]  sum_new;
  logic [MAG_W-1:0]  sum_mag;
  logic [MQ_W-1:0]   mean_q;

  // innovation and square sum update
  logic [X_W:0]      innov_diff;
  logic [X_W-1:0]    innov_sat;
  logic [X_W:0]      d_val;
  logic [X_W:0]      s_val;
  logic [X_W:0]      d_neg;
  logic [X_W:0]      s_neg;
  logic [MB_W-1:0]   d_mag;
  logic [MA_W-1:0]   s_mag;
  logic              prod_neg;
  logic              prod_neg_r;
  logic [SQ_W-1:0]   prod_ext;
  logic [SQ_W-1:0]   sq_new;
  logic [POS_W-1:0]  pos_cur;
  logic [POS_W-1:0]  pos_new;
  logic              pos_wrap;
  logic [WU_W-1:0]   warm_cur;
  logic [WU_W-1:0]   warm_new;
  logic              ready_new;

  // units
  logic                div_start;
  logic [DV_W-1:0]     div_dividend;
  logic [DL_W-1:0]     div_len;
  logic [DV_W-1:0]     div_quot;
  unit_stat_t          div_stat;
  logic                mul_start;
  logic [PR_W-1:0]     mul_prod;
  unit_stat_t          mul_stat;
  logic                sqrt_start;
  logic [ROOT_W-1:0]   sqrt_root;
  unit_stat_t          sqrt_stat;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || out_tready);

  assign in_range = (32'(in_tuser[1:0]) < GYROS) && (32'(in_tuser[3:2]) < AXES);
  assign c_in     = CH_W'(32'(in_tuser[1:0]) * AXES + 32'(in_tuser[3:2]));

  // old slot reads as zero until this channel's window has wrapped once
  assign old_ok  = wrap_arr_r[c_r];
  assign old_x   = old_ok ? ram_rdata[X_W-1:0] : '0;
  assign old_i   = old_ok ? ram_rdata[2*X_W-1:X_W] : '0;
  assign sum_cur = sum_arr_r[c_r];
  assign sum_new = sum_cur - {{(SUM_W - X_W){old_x[X_W-1]}}, old_x}
                           + {{(SUM_W - X_W){x_r[X_W-1]}}, x_r};

  // floor(s / W) for s < 0 is ~floor(~s / W)
  assign sum_mag = sum_cur[SUM_W-1] ? ~sum_cur[MAG_W-1:0] : sum_cur[MAG_W-1:0];
  assign mean_q  = div_quot[MQ_W-1:0];

  // innovation, saturated to the sample range
  assign innov_diff = {x_r[X_W-1], x_r} - {mean_r[X_W-1], mean_r};
  always_comb begin
    if (innov_diff[X_W] != innov_diff[X_W-1]) begin
      innov_sat = innov_diff[X_W] ? {1'b1, {(X_W - 1){1'b0}}} : {1'b0, {(X_W - 1){1'b1}}};
    end else begin
      innov_sat = innov_diff[X_W-1:0];
    end
  end

  // new^2 - old^2 as a signed product of magnitudes
  assign d_val    = {innov_r[X_W-1], innov_r} - {old_i_r[X_W-1], old_i_r};
  assign s_val    = {innov_r[X_W-1], innov_r} + {old_i_r[X_W-1], old_i_r};
  assign d_neg    = -d_val;
  assign s_neg    = -s_val;
  assign d_mag    = d_val[X_W] ? d_neg[MB_W-1:0] : d_val[MB_W-1:0];
  assign s_mag    = s_val[X_W] ? s_neg : s_val;
  assign prod_neg = d_val[X_W] ^ s_val[X_W];
  assign prod_ext = SQ_W'(mul_prod);
  assign sq_new   = prod_neg_r ? sq_arr_r[c_r] - prod_ext : sq_arr_r[c_r] + prod_ext;

  assign pos_cur   = pos_arr_r[c_r];
  assign pos_wrap  = (pos_cur == POS_W'(WINDOW - 1));
  assign pos_new   = pos_wrap ? '0 : pos_cur + POS_W'(1);
  assign warm_cur  = warm_arr_r[c_r];
  assign warm_new  = (32'(warm_cur) < WARMUP) ? warm_cur + WU_W'(1) : warm_cur;
  assign ready_new = (32'(warm_new) == WARMUP);

  // shared divider: window sum first, then square sum
  assign div_start    = (state_r == ST_MDIV0) || (state_r == ST_SDIV0);
  assign div_dividend = (state_r == ST_MDIV0) ? {sum_mag, {(DV_W - MAG_W){1'b0}}}
                                              : sq_arr_r[c_r];
  assign div_len      = (state_r == ST_MDIV0) ? DL_W'(MAG_W) : DL_W'(SQ_W);

  assign mul_start  = (state_r == ST_MUL0);
  assign sqrt_start = (state_r == ST_SDIV) && div_stat.done;

  // sample and innovation windows, one slot per channel and position
  swmr_ram #(
    .WIDTH (2 * X_W),
    .DEPTH (DEPTH)
  ) u_win_ram (
    .clk   (clk),
    .we    (state_r == ST_MUL0),
    .waddr (addr_r),
    .wdata ({innov_r, x_r}),
    .re    (state_r == ST_READ),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  swmr_cdiv u_cdiv (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .len      (div_len),
    .quot     (div_quot),
    .stat     (div_stat)
  );

  swmr_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a_in  (s_mag),
    .b_in  (d_mag),
    .prod  (mul_prod),
    .stat  (mul_stat)
  );

  swmr_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .rad   (div_quot[RAD_W-1:0]),
    .root  (sqrt_root),
    .stat  (sqrt_stat)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = range_ok_r ? ST_READ : ST_FIN;
      ST_READ:  state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_MDIV0;
      ST_MDIV0: state_nxt = ST_MDIV;
      ST_MDIV:  if (div_stat.done) state_nxt = ST_INNOV;
      ST_INNOV: state_nxt = ST_MUL0;
      ST_MUL0:  state_nxt = ST_MUL;
      ST_MUL:   if (mul_stat.done) state_nxt = ready_new ? ST_SDIV0 : ST_FIN;
      ST_SDIV0: state_nxt = ST_SDIV;
      ST_SDIV:  if (div_stat.done) state_nxt = ST_SQRT;
      ST_SQRT:  if (sqrt_stat.done) state_nxt = ST_FIN;
      ST_FIN:   if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control state and per-channel sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < CH; i++) begin
        sum_arr_r[i]  <= '0;
        sq_arr_r[i]   <= '0;
        pos_arr_r[i]  <= '0;
        wrap_arr_r[i] <= 1'b0;
        warm_arr_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_SUM) begin
        sum_arr_r[c_r] <= sum_new;
      end
      if ((state_r == ST_MUL) && mul_stat.done) begin
        sq_arr_r[c_r]   <= sq_new;
        pos_arr_r[c_r]  <= pos_new;
        warm_arr_r[c_r] <= warm_new;
        if (pos_wrap) begin
          wrap_arr_r[c_r] <= 1'b1;
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      g_r        <= in_tuser[1:0];
      a_r        <= in_tuser[3:2];
      x_r        <= in_tdata;
      c_r        <= c_in;
      range_ok_r <= in_range;
    end
    if (state_r == ST_ADDR) begin
      addr_r <= ADDR_W'(32'(c_r) * WINDOW + 32'(pos_cur));
      if (!range_ok_r) begin
        mean_r <= '0;
        rms_r  <= '0;
        rdy_r  <= 1'b0;
      end
    end
    if (state_r == ST_SUM) begin
      old_i_r <= old_i;
    end
    if ((state_r == ST_MDIV) && div_stat.done) begin
      mean_r <= sum_cur[SUM_W-1] ? ~{1'b0, mean_q} : {1'b0, mean_q};
    end
    if (state_r == ST_INNOV) begin
      innov_r <= innov_sat;
    end
    if (state_r == ST_MUL0) begin
      prod_neg_r <= prod_neg;
    end
    if ((state_r == ST_MUL) && mul_stat.done) begin
      rdy_r <= ready_new;
      rms_r <= '0;
    end
    if ((state_r == ST_SQRT) && sqrt_stat.done) begin
      rms_r <= sqrt_root[ROOT_W-1] ? {RMS_W{1'b1}} : sqrt_root[RMS_W-1:0];
    end
    if (out_load) begin
      out_data_r <= {1'b0, rms_r, mean_r};
      out_user_r <= {rdy_r, a_r, g_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef NO_ASSERTIONS
  // a new sample never lands while a serial unit is still working
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !div_stat.busy && !mul_stat.busy && !sqrt_stat.busy)
    else $error("sample accepted while a unit is busy");

  // divider results only arrive in the states that wait for them
  assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_MDIV) || (state_r == ST_SDIV))
    else $error("divider finished outside a wait state");

  // root stays zero in any result that is not ready
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[4] |-> out_tdata[46:24] == '0)
    else $error("nonzero rms before warmup");

  // write position of the active channel stays inside the window
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) && range_ok_r |-> 32'(pos_arr_r[c_r]) < WINDOW)
    else $error("write position beyond window");
`endif

endmodule

// ===== sv/swmr_ram.sv =====
module swmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/swmr_cdiv.sv =====
module swmr_cdiv (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [swmr_pkg::DV_W-1:0]          dividend,
  input  logic [swmr_pkg::DL_W-1:0]          len,
  output logic [swmr_pkg::DV_W-1:0]          quot,
  output swmr_pkg::unit_stat_t               stat
);
  import swmr_pkg::*;

  // restoring division by the window length, one quotient bit per cycle;
  // the dividend comes in left justified and the quotient shifts in below
  logic [DV_W-1:0]   dv_r;
  logic [WIN_CW-1:0] rem_r;
  logic [DL_W-1:0]   cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [WIN_CW:0]   trial;
  logic [WIN_CW:0]   diff;
  logic              ge;

  assign trial = {rem_r, dv_r[DV_W-1]};
  assign ge    = trial >= (WIN_CW + 1)'(WINDOW);
  assign diff  = trial - (WIN_CW + 1)'(WINDOW);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= len;
      end else if (busy_r) begin
        cnt_r <= cnt_r - DL_W'(1);
        if (cnt_r == DL_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dv_r  <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[WIN_CW-1:0] : trial[WIN_CW-1:0];
      dv_r  <= {dv_r[DV_W-2:0], ge};
    end
  end

  assign quot      = dv_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== sv/swmr_mul.sv =====
module swmr_mul (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [swmr_pkg::MA_W-1:0]     a_in,
  input  logic [swmr_pkg::MB_W-1:0]     b_in,
  output logic [swmr_pkg::PR_W-1:0]     prod,
  output swmr_pkg::unit_stat_t          stat
);
  import swmr_pkg::*;

  // shift-add multiply, one multiplier bit per cycle
  logic [PR_W-1:0] acc_r;
  logic [PR_W-1:0] a_r;
  logic [MB_W-1:0] b_r;
  logic [MC_W-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= MC_W'(MB_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - MC_W'(1);
        if (cnt_r == MC_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= PR_W'(a_in);
      b_r   <= b_in;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= acc_r + a_r;
      end
      a_r <= {a_r[PR_W-2:0], 1'b0};
      b_r <= {1'b0, b_r[MB_W-1:1]};
    end
  end

  assign prod      = acc_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== sv/swmr_sqrt.sv =====
module swmr_sqrt (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [swmr_pkg::RAD_W-1:0]     rad,
  output logic [swmr_pkg::ROOT_W-1:0]    root,
  output swmr_pkg::unit_stat_t           stat
);
  import swmr_pkg::*;

  // digit-by-digit floor root, two radicand bits in and one root bit out per cycle
  logic [RAD_W-1:0]   rad_r;
  logic [REM_W-1:0]   rem_r;
  logic [ROOT_W-1:0]  root_r;
  logic [SC_W-1:0]    cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [REM_W+1:0]   cur;
  logic [REM_W+1:0]   trial;
  logic [REM_W+1:0]   diff;
  logic               ge;

  assign cur   = {rem_r, rad_r[RAD_W-1:RAD_W-2]};
  assign trial = (REM_W + 2)'({root_r, 2'b01});
  assign ge    = cur >= trial;
  assign diff  = cur - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= SC_W'(ROOT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - SC_W'(1);
        if (cnt_r == SC_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= rad;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rem_r  <= ge ? diff[REM_W-1:0] : cur[REM_W-1:0];
      root_r <= {root_r[ROOT_W-2:0], ge};
      rad_r  <= {rad_r[RAD_W-3:0], 2'b00};
    end
  end

  assign root      = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

// ===== sim/window_stats_checker.sv =====
`timescale 1ns / 100ps

module window_stats_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // rate_sample
  input  logic [3:0]  in_tuser,   // gyro_index, axis_index
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,  // window_mean, innovation_rms, pad
  input  logic [4:0]  out_tuser,  // out_gyro, out_axis, ready_res
  output int          mismatch_total,
  output int          results_pending
);
  import swmr_pkg::*;

  localparam longint INNOV_MAX = (longint'(1) << (X_W - 1)) - 1;
  localparam longint INNOV_MIN = -INNOV_MAX - 1;
  localparam longint RMS_MAX   = (longint'(1) << RMS_W) - 1;

  typedef struct packed {
    logic [IDX_W-1:0]      gyro;
    logic [IDX_W-1:0]      axis;
    logic signed [X_W-1:0] mean;
    logic [RMS_W-1:0]      rms;
    logic                  ready;
  } window_stats_t;

  // per-channel history and exact running sums
  logic signed [X_W-1:0] sample_hist [CH][WINDOW];
  logic signed [X_W-1:0] innov_hist  [CH][WINDOW];
  longint                win_sum     [CH];
  longint unsigned       sq_sum      [CH];
  int                    wr_slot     [CH];
  int                    seen_count  [CH];

  window_stats_t expected_stats [$];
  window_stats_t got_stats;
  window_stats_t want_stats;
  int            fail_count = 0;

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic window_stats_t predict_window_stats(
    input logic [IDX_W-1:0]      g,
    input logic [IDX_W-1:0]      a,
    input logic signed [X_W-1:0] x
  );
    window_stats_t   res;
    int              c;
    int              p;
    longint          xs;
    longint          mean;
    longint          innov;
    longint          prev;
    longint unsigned root;
    res      = '0;
    res.gyro = g;
    res.axis = a;
    // channel out of range leaves all state alone
    if (g >= GYROS || a >= AXES) return res;
    c  = g * AXES + a;
    p  = wr_slot[c];
    xs = longint'(x);
    win_sum[c]        = win_sum[c] - longint'(sample_hist[c][p]) + xs;
    sample_hist[c][p] = x;
    mean = win_sum[c] / WINDOW;
    if (win_sum[c] % WINDOW != 0 && win_sum[c] < 0) mean = mean - 1;
    innov = xs - mean;
    if (innov > INNOV_MAX) innov = INNOV_MAX;
    if (innov < INNOV_MIN) innov = INNOV_MIN;
    prev = longint'(innov_hist[c][p]);
    sq_sum[c] = sq_sum[c] - longint'(prev * prev) + longint'(innov * innov);
    innov_hist[c][p] = X_W'(innov);
    wr_slot[c] = (p + 1 == WINDOW) ? 0 : p + 1;
    if (seen_count[c] < WARMUP) seen_count[c]++;
    res.mean = X_W'(mean);
    if (seen_count[c] >= WARMUP) begin
      root = floor_sqrt(sq_sum[c] / WINDOW);
      if (root > RMS_MAX) root = RMS_MAX;
      res.rms   = RMS_W'(root);
      res.ready = 1'b1;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CH; c++) begin
        win_sum[c]    = 0;
        sq_sum[c]     = 0;
        wr_slot[c]    = 0;
        seen_count[c] = 0;
        for (int p = 0; p < WINDOW; p++) begin
          sample_hist[c][p] = '0;
          innov_hist[c][p]  = '0;
        end
      end
      expected_stats.delete();
    end else begin
      if (in_tvalid && in_tready)
        expected_stats.push_back(predict_window_stats(in_tuser[IDX_W-1:0],
                                                      in_tuser[2*IDX_W-1:IDX_W],
                                                      in_tdata[X_W-1:0]));
      if (out_tvalid && out_tready) begin
        got_stats.gyro  = out_tuser[IDX_W-1:0];
        got_stats.axis  = out_tuser[2*IDX_W-1:IDX_W];
        got_stats.ready = out_tuser[2*IDX_W];
        got_stats.mean  = out_tdata[X_W-1:0];
        got_stats.rms   = out_tdata[X_W+RMS_W-1:X_W];
        if (expected_stats.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result beat: gyro %0d axis %0d mean %0d rms %0d ready %0b",
                     got_stats.gyro, got_stats.axis, got_stats.mean, got_stats.rms,
                     got_stats.ready);
          fail_count++;
        end else begin
          want_stats = expected_stats.pop_front();
          if (got_stats.gyro !== want_stats.gyro || got_stats.axis !== want_stats.axis ||
              got_stats.mean !== want_stats.mean || got_stats.rms !== want_stats.rms ||
              got_stats.ready !== want_stats.ready) begin
            if (fail_count < 10) begin
              $display("result mismatch: expected gyro %0d axis %0d mean %0d rms %0d ready %0b",
                       want_stats.gyro, want_stats.axis, want_stats.mean, want_stats.rms,
                       want_stats.ready);
              $display("                 actual   gyro %0d axis %0d mean %0d rms %0d ready %0b",
                       got_stats.gyro, got_stats.axis, got_stats.mean, got_stats.rms,
                       got_stats.ready);
            end
            fail_count++;
          end
        end
      end
    end
    mismatch_total  <= fail_count;
    results_pending <= expected_stats.size();
  end

endmodule

// ===== sim/sliding_window_mean_rms_tb.sv =====
`timescale 1ns / 100ps

module sliding_window_mean_rms_tb;
  import swmr_pkg::*;

  // watchdog limit: well above the slowest correct run, with every beat taking
  // the full per-item time plus the longest send gap and the longest stall
  localparam int LIMIT_CYCLES = 2_000_000;
  // tail wait after the last result, above the per-item time of a ready channel
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_ITEMS = 1880;

  // two hot channels collect most of the traffic so they pass warmup
  localparam logic [IDX_W-1:0] HOT_A_GYRO = 2'd0;
  localparam logic [IDX_W-1:0] HOT_A_AXIS = 2'd0;
  localparam logic [IDX_W-1:0] HOT_B_GYRO = 2'd2;
  localparam logic [IDX_W-1:0] HOT_B_AXIS = 2'd2;
  localparam logic [IDX_W-1:0] BAD_INDEX  = 2'd3;

  localparam logic [X_W-1:0] RATE_MAX = 24'h7fffff;
  localparam logic [X_W-1:0] RATE_MIN = 24'h800000;
  localparam logic [X_W-1:0] RATE_NEG_ONE = 24'hffffff;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // rate_sample
  logic [3:0]  in_tuser = '0;   // gyro_index, axis_index
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // window_mean, innovation_rms, pad
  logic [4:0]  out_tuser;       // out_gyro, out_axis, ready_res

  int mismatch_total;
  int results_pending;

  // stretch with no idling on either side
  bit steady_flow = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sliding_window_mean_rms dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  window_stats_checker stats_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .mismatch_total  (mismatch_total),
    .results_pending (results_pending)
  );

  // mostly no gap, some short ones, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 50) return 0;
    if (r < 96) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // present one sample beat and hold it until the block takes it
  task automatic send_sample(input logic [IDX_W-1:0] g, input logic [IDX_W-1:0] a,
                             input logic [X_W-1:0] x);
    in_tvalid <= 1'b1;
    in_tdata  <= x;
    in_tuser  <= {a, g};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic hold_off(input int cycles);
    if (cycles > 0) begin
      in_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // wait on clock edges until the checker holds no more expectations
  task automatic wait_results_drained();
    do @(posedge clk); while (results_pending != 0);
  endtask

  // result side backpressure: random stalls except in the steady stretch
  initial begin : sink_pacing
    int stall_left;
    int r;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (stall_left > 0 && !steady_flow) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
        stall_left = 0;
        r = $urandom_range(0, 99);
        if (!steady_flow && r < 25)
          stall_left = (r < 23) ? $urandom_range(1, 4) : $urandom_range(20, 80);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    logic [IDX_W-1:0] g;
    logic [IDX_W-1:0] a;
    logic [X_W-1:0]   x;
    int               drift;
    int               r;
    int               c;

    // reset, once
    rst_n <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // out-of-range channels: indices echo back, everything else zero
    send_sample(BAD_INDEX, 2'd0, RATE_MAX);
    hold_off(pick_gap());
    send_sample(2'd0, BAD_INDEX, RATE_MIN);
    hold_off(pick_gap());
    send_sample(BAD_INDEX, BAD_INDEX, 24'h123456);
    hold_off(pick_gap());

    // first beat on every channel: full-scale both ways and -1 (floor of a negative mean)
    for (c = 0; c < CH; c++) begin
      g = IDX_W'(c / AXES);
      a = IDX_W'(c % AXES);
      x = (c % 3 == 0) ? RATE_MAX : (c % 3 == 1) ? RATE_MIN : RATE_NEG_ONE;
      send_sample(g, a, x);
      hold_off(pick_gap());
    end

    // channel 1/0 starts high: two highs then a low saturates the innovation negative
    send_sample(2'd1, 2'd0, RATE_MAX);
    hold_off(pick_gap());
    send_sample(2'd1, 2'd0, RATE_MIN);
    hold_off(pick_gap());
    // channel 1/1 starts low: two lows then a high saturates it positive
    send_sample(2'd1, 2'd1, RATE_MIN);
    hold_off(pick_gap());
    send_sample(2'd1, 2'd1, RATE_MAX);
    hold_off(pick_gap());
    send_sample(HOT_A_GYRO, HOT_A_AXIS, '0);
    hold_off(pick_gap());

    // random traffic: mostly a wandering rate with small noise on two hot channels
    drift = int'($urandom_range(0, 200000)) - 100000;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_flow = (n >= 900 && n < 1100);

      r = $urandom_range(0, 99);
      if (r < 38) begin
        g = HOT_A_GYRO;
        a = HOT_A_AXIS;
      end else if (r < 76) begin
        g = HOT_B_GYRO;
        a = HOT_B_AXIS;
      end else if (r < 92) begin
        g = IDX_W'($urandom_range(0, GYROS - 1));
        a = IDX_W'($urandom_range(0, AXES - 1));
      end else begin
        // out-of-range noise, every index bit pattern reachable
        g = IDX_W'($urandom_range(0, 3));
        a = IDX_W'($urandom_range(0, 3));
        if ($urandom_range(0, 1)) g = BAD_INDEX;
        else a = BAD_INDEX;
      end

      drift = drift + int'($urandom_range(0, 64)) - 32;
      r = $urandom_range(0, 99);
      if (r < 70) x = X_W'(drift + int'($urandom_range(0, 4095)) - 2048);
      else if (r < 92) x = X_W'($urandom());
      else if (r < 96) x = RATE_MAX;
      else x = RATE_MIN;

      send_sample(g, a, x);

      // twice the sender holds back until every result is out
      if (n == 600 || n == 1500) begin
        in_tvalid <= 1'b0;
        wait_results_drained();
      end else begin
        hold_off(pick_gap());
      end
    end
    steady_flow = 1'b0;
    in_tvalid <= 1'b0;

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_total == 0 && results_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
